>>> src/u8cp_pkg.sv
// Shared types, byte classes and Windows-1252 fallback tables for the UTF-8 sanitizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8cp_pkg;

    // Byte class, decided in the front part from the lead-byte bit pattern
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } cls_t;

    // One input byte after classification
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        cls_t       cls;
    } item_t;

    // Engine write into the output queue
    typedef struct packed {
        logic       emit;   // a result byte is written this cycle
        logic [7:0] data;
        logic       start;
        logic       fin;    // all results of the current input are written
    } wr_t;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;
    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LEAD_C3    = 8'hC3;
    localparam logic [7:0] LATIN_OFS  = 8'h40;
    localparam logic [7:0] NBSP_CODE  = 8'hA0;
    localparam logic [7:0] LATIN_CODE = 8'hC0;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        if (!b[7])
            c = CLS_ASCII;
        else if ((b & MASK_CONT) == PAT_CONT)
            c = CLS_CONT;
        else if ((b & MASK_LEAD2) == PAT_LEAD2)
            c = CLS_LEAD2;
        else if ((b & MASK_LEAD3) == PAT_LEAD3)
            c = CLS_LEAD3;
        else if ((b & MASK_LEAD4) == PAT_LEAD4)
            c = CLS_LEAD4;
        else
            c = CLS_BAD;
        return c;
    endfunction

    // Sequence length implied by a class; 0 for bytes that cannot lead
    function automatic logic [2:0] seq_len(input cls_t c);
        logic [2:0] l;
        case (c)
            CLS_ASCII: l = 3'd1;
            CLS_LEAD2: l = 3'd2;
            CLS_LEAD3: l = 3'd3;
            CLS_LEAD4: l = 3'd4;
            default:   l = 3'd0;
        endcase
        return l;
    endfunction

    // Windows-1252 0x80..0x9F as UTF-8, first byte in the top lane
    function automatic logic [23:0] cp_row(input logic [4:0] idx);
        logic [23:0] r;
        case (idx)
            5'h00: r = 24'hE282AC;
            5'h02: r = 24'hE2809A;
            5'h03: r = 24'hC69200;
            5'h04: r = 24'hE2809E;
            5'h05: r = 24'hE280A6;
            5'h06: r = 24'hE280A0;
            5'h07: r = 24'hE280A1;
            5'h08: r = 24'hCB8600;
            5'h09: r = 24'hE280B0;
            5'h0A: r = 24'hC5A000;
            5'h0B: r = 24'hE280B9;
            5'h0C: r = 24'hC59200;
            5'h0E: r = 24'hC5BD00;
            5'h11: r = 24'hE28098;
            5'h12: r = 24'hE28099;
            5'h13: r = 24'hE2809C;
            5'h14: r = 24'hE2809D;
            5'h15: r = 24'hE280A2;
            5'h16: r = 24'hE28093;
            5'h17: r = 24'hE28094;
            5'h18: r = 24'hCB9C00;
            5'h19: r = 24'hE284A2;
            5'h1A: r = 24'hC5A100;
            5'h1B: r = 24'hE280BA;
            5'h1C: r = 24'hC59300;
            5'h1E: r = 24'hC5BE00;
            5'h1F: r = 24'hC5B800;
            default: r = 24'h000000;  // undefined codes
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cp_len(input logic [4:0] idx);
        logic [1:0] l;
        case (idx)
            5'h01, 5'h0D, 5'h0F, 5'h10, 5'h1D:
                l = 2'd0;
            5'h03, 5'h08, 5'h0A, 5'h0C, 5'h0E, 5'h18, 5'h1A, 5'h1C, 5'h1E, 5'h1F:
                l = 2'd2;
            default:
                l = 2'd3;
        endcase
        return l;
    endfunction

    // Number of bytes a fallback lead expands to (b is 0x80 or above)
    function automatic logic [1:0] fb_len(input logic [7:0] b);
        return (b < NBSP_CODE) ? cp_len(b[4:0]) : 2'd2;
    endfunction

    // Byte k of the fallback expansion of b
    function automatic logic [7:0] fb_byte(input logic [7:0] b, input logic [1:0] k);
        logic [23:0] row;
        logic [7:0]  r;
        row = cp_row(b[4:0]);
        if (b < NBSP_CODE) begin
            case (k)
                2'd0:    r = row[23:16];
                2'd1:    r = row[15:8];
                default: r = row[7:0];
            endcase
        end else if (b < LATIN_CODE) begin
            r = (k == 2'd0) ? LEAD_C2 : b;
        end else begin
            r = (k == 2'd0) ? LEAD_C3 : b - LATIN_OFS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/utf8_sanitizer_cp1252_fallback_top.sv
// Top level of the UTF-8 sanitizer with Windows-1252 fallback.
// Depends on u8cp_pkg, u8cp_front, u8cp_engine and u8cp_outq.
`default_nettype none

//  channel  | ports                              | transfer when
//  ---------+------------------------------------+--------------------
//  input    | push, full, in_byte, in_last       | push && !full
//  result   | empty, pop, out_byte, char_start,  | pop && !empty
//           | run_last                           |
//
//  The engine makes one engine step per cycle while the result queue is not full,
//  and each step writes at most one result byte.
//  Results of an input show on the result side once all of them are written.
//  Reset clears all queue pointers and the held count; held bytes need no clear.
//  A full result queue stalls the engine; the input queue then fills and raises
//  full. Either side may stall at any time without loss.

module utf8_sanitizer_cp1252_fallback_top #(
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 16   // at least 12: one input's results must fit
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             char_start,
    output logic             run_last
);
    import u8cp_pkg::*;

    item_t  item;
    logic   item_valid;
    logic   item_take;
    wr_t    wr;
    logic   wr_full;

    // classify and queue incoming bytes
    u8cp_front #(
        .DEPTH      (IN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // validate sequences, hold partial ones, expand fallback leads
    u8cp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_full   (wr_full),
        .wr         (wr)
    );

    // result bytes, released per input with run_last on the final one
    u8cp_outq #(
        .DEPTH      (OUT_DEPTH)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .wr_full    (wr_full),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .char_start (char_start),
        .run_last   (run_last)
    );

endmodule

`default_nettype wire

>>> src/u8cp_front.sv
// Front part: input queue that classifies each byte as it is pushed.
// Depends on u8cp_pkg (item_t, classify).
`default_nettype none

module u8cp_front #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_last,
    output logic                 item_valid,
    output u8cp_pkg::item_t      item,
    input  wire logic            item_take
);
    import u8cp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           slot_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= '{data: in_byte, last: in_last, cls: classify(in_byte)};
        end
    end

endmodule

`default_nettype wire

>>> src/u8cp_engine.sv
// Back part: walks held bytes plus the new byte, at most one result byte per cycle.
// Depends on u8cp_pkg (item_t, wr_t, seq_len, fb_len, fb_byte).
`default_nettype none

module u8cp_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire u8cp_pkg::item_t item,
    output logic                 item_take,
    input  wire logic            out_full,
    output u8cp_pkg::wr_t        wr
);
    import u8cp_pkg::*;

    // working buffer of the current input
    logic        busy_reg, busy_next;
    logic [2:0]  n_reg, n_next;
    logic [1:0]  p_reg, p_next;
    logic [1:0]  k_reg, k_next;
    logic        last_reg, last_next;
    logic [7:0]  buf_reg [4];
    cls_t        cls_reg [4];
    // incomplete sequence carried to the next input
    logic [7:0]  held_reg [3];
    cls_t        hcls_reg [3];
    logic [1:0]  hcnt_reg, hcnt_next;

    logic [7:0]  cur_buf [4];
    cls_t        cur_cls [4];
    logic [2:0]  cur_n;
    logic [1:0]  cur_p;
    logic [1:0]  cur_k;
    logic        cur_last;
    logic        src_valid;

    logic [7:0]  b;
    logic [2:0]  len;
    logic [2:0]  avail;
    logic        ok;
    logic        complete;
    logic        is_ascii;
    logic        is_seq;
    logic        is_hold;
    logic [1:0]  flen;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        final_sub;
    logic [2:0]  adv;
    logic [2:0]  new_p;
    logic        fin;
    logic        go;
    logic [2:0]  pos;

    // current view: registered buffer, or held bytes plus the queue head
    always_comb
    begin
        if (busy_reg)
        begin
            cur_buf   = buf_reg;
            cur_cls   = cls_reg;
            cur_n     = n_reg;
            cur_p     = p_reg;
            cur_k     = k_reg;
            cur_last  = last_reg;
            src_valid = 1'b1;
        end
        else
        begin
            cur_buf[0] = (hcnt_reg == 2'd0) ? item.data : held_reg[0];
            cur_cls[0] = (hcnt_reg == 2'd0) ? item.cls  : hcls_reg[0];
            cur_buf[1] = (hcnt_reg == 2'd1) ? item.data : held_reg[1];
            cur_cls[1] = (hcnt_reg == 2'd1) ? item.cls  : hcls_reg[1];
            cur_buf[2] = (hcnt_reg == 2'd2) ? item.data : held_reg[2];
            cur_cls[2] = (hcnt_reg == 2'd2) ? item.cls  : hcls_reg[2];
            cur_buf[3] = item.data;
            cur_cls[3] = item.cls;
            cur_n      = {1'b0, hcnt_reg} + 3'd1;
            cur_p      = 2'd0;
            cur_k      = 2'd0;
            cur_last   = item.last;
            src_valid  = item_valid;
        end
    end

    // decode of the sequence that starts at the current position
    always_comb
    begin
        b     = cur_buf[cur_p];
        len   = seq_len(cur_cls[cur_p]);
        avail = cur_n - {1'b0, cur_p};
        ok    = 1'b1;
        for (int j = 1; j < 4; j++)
        begin
            if ((3'(j) < len) && (3'(j) < avail)
                && (cur_cls[cur_p + 2'(j)] != CLS_CONT))
            begin
                ok = 1'b0;
            end
        end
        complete = ok && (avail >= len);
        is_ascii = (len == 3'd1);
        is_seq   = (len >= 3'd2) && complete;
        is_hold  = (len >= 3'd2) && ok && !complete && !cur_last;
        flen     = fb_len(b);
        pos      = {1'b0, cur_p} + {1'b0, cur_k};
    end

    // what this step emits and how far it moves
    always_comb
    begin
        if (is_ascii)
        begin
            emit      = 1'b1;
            emit_byte = b;
            final_sub = 1'b1;
            adv       = 3'd1;
        end
        else if (is_seq)
        begin
            emit      = 1'b1;
            emit_byte = cur_buf[pos[1:0]];
            final_sub = ({1'b0, cur_k} == len - 3'd1);
            adv       = len;
        end
        else if (is_hold)
        begin
            emit      = 1'b0;
            emit_byte = b;
            final_sub = 1'b1;
            adv       = 3'd0;
        end
        else
        begin
            // fallback: undefined codes expand to nothing
            emit      = (flen != 2'd0);
            emit_byte = fb_byte(b, cur_k);
            final_sub = (flen == 2'd0) || (cur_k == flen - 2'd1);
            adv       = 3'd1;
        end
        new_p = {1'b0, cur_p} + adv;
        fin   = is_hold || (final_sub && (new_p == cur_n));
        go    = src_valid && !out_full;
    end

    assign item_take = go && !busy_reg;
    assign wr = '{emit: go && emit, data: emit_byte, start: (cur_k == 2'd0),
                  fin: go && fin};

    always_comb
    begin
        busy_next = busy_reg;
        n_next    = n_reg;
        p_next    = p_reg;
        k_next    = k_reg;
        last_next = last_reg;
        hcnt_next = hcnt_reg;
        if (go)
        begin
            busy_next = !fin;
            n_next    = cur_n;
            last_next = cur_last;
            p_next    = final_sub ? new_p[1:0] : cur_p;
            k_next    = final_sub ? 2'd0 : cur_k + 2'd1;
            if (fin)
            begin
                hcnt_next = is_hold ? avail[1:0] : 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
            p_reg    <= '0;
            k_reg    <= '0;
            last_reg <= 1'b0;
            hcnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
            p_reg    <= p_next;
            k_reg    <= k_next;
            last_reg <= last_next;
            hcnt_reg <= hcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && !busy_reg)
        begin
            buf_reg <= cur_buf;
            cls_reg <= cur_cls;
        end
        if (go && is_hold)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i] <= cur_buf[cur_p + 2'(i)];
                hcls_reg[i] <= cur_cls[cur_p + 2'(i)];
            end
        end
    end

endmodule

`default_nettype wire

>>> src/u8cp_outq.sv
// Result queue with a commit point: results of one input become visible together.
// Depends on u8cp_pkg (wr_t).
`default_nettype none

module u8cp_outq #(
    parameter int DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire u8cp_pkg::wr_t   wr,
    output logic                 wr_full,
    output logic                 empty,
    input  wire logic            pop,
    output logic [7:0]           out_byte,
    output logic                 char_start,
    output logic                 run_last
);
    import u8cp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]     data_reg  [DEPTH];
    logic           start_reg [DEPTH];
    logic           rl_reg    [DEPTH];
    logic [AW-1:0]  wr_reg, wr_next;
    logic [AW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  total_reg, total_next;   // written, not yet read
    logic [CW-1:0]  commit_reg, commit_next; // visible, not yet read
    logic [AW-1:0]  prev_idx;
    logic           do_pop;

    assign wr_full    = (total_reg == CW'(DEPTH));
    assign empty      = (commit_reg == '0);
    assign do_pop     = pop && !empty;
    assign out_byte   = data_reg[rd_reg];
    assign char_start = start_reg[rd_reg];
    assign run_last   = rl_reg[rd_reg];
    assign prev_idx   = (wr_reg == '0) ? AW'(DEPTH - 1) : wr_reg - 1'b1;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (wr.emit)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        total_next  = total_reg + CW'(wr.emit) - CW'(do_pop);
        commit_next = wr.fin ? total_next : commit_reg - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg     <= '0;
            rd_reg     <= '0;
            total_reg  <= '0;
            commit_reg <= '0;
        end
        else
        begin
            wr_reg     <= wr_next;
            rd_reg     <= rd_next;
            total_reg  <= total_next;
            commit_reg <= commit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.emit)
        begin
            data_reg[wr_reg]  <= wr.data;
            start_reg[wr_reg] <= wr.start;
            rl_reg[wr_reg]    <= wr.fin;
        end
        else if (wr.fin && (total_reg != commit_reg))
        begin
            // input ended without a byte this cycle: tag its last written byte
            rl_reg[prev_idx] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> bench/utf8_sanitizer_cp1252_fallback_top_test.sv
// Self-checking testbench for utf8_sanitizer_cp1252_fallback_top.
// It predicts every output byte and compares it with what the block emits.
// Depends on u8cp_pkg for the lead-byte masks and fallback constants.
module utf8_sanitizer_cp1252_fallback_top_test;

    import u8cp_pkg::*;

    localparam int RANDOM_ITEMS = 340;
    localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
    localparam int TAIL_CYCLES  = 60;    // engine worst case plus a long receiver stall

    // One expected output byte, in port order
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       fin;
    } utf8_result_t;

    // One raw input byte waiting for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain_first;  // hold it back until every expected byte has come out
    } raw_byte_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       char_start;
    logic       run_last;

    utf8_sanitizer_cp1252_fallback_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .char_start (char_start),
        .run_last   (run_last)
    );

    raw_byte_t    pending_bytes [$];
    utf8_result_t expected_utf8 [$];
    int           err_count   = 0;
    int           idle_cycles = 0;
    bit           drain_next  = 1'b0;

    // Predictor state: the incomplete sequence carried between input bytes
    logic [7:0] held [3];
    logic [1:0] held_n   = 2'd0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Length a lead byte announces; 0 for continuation bytes and F8..FF
    function automatic int lead_len(input logic [7:0] b);
        int len;
        if (!b[7])
            len = 1;
        else if ((b & MASK_LEAD2) == PAT_LEAD2)
            len = 2;
        else if ((b & MASK_LEAD3) == PAT_LEAD3)
            len = 3;
        else if ((b & MASK_LEAD4) == PAT_LEAD4)
            len = 4;
        else
            len = 0;
        return len;
    endfunction

    // Windows-1252 0x80..0x9F as UTF-8: {byte count, bytes first-in-top}
    function automatic logic [25:0] cp1252_utf8(input logic [4:0] idx);
        logic [25:0] r;
        case (idx)
            5'h00: r = {2'd3, 24'hE282AC};  // euro sign
            5'h02: r = {2'd3, 24'hE2809A};
            5'h03: r = {2'd2, 24'hC69200};
            5'h04: r = {2'd3, 24'hE2809E};
            5'h05: r = {2'd3, 24'hE280A6};
            5'h06: r = {2'd3, 24'hE280A0};
            5'h07: r = {2'd3, 24'hE280A1};
            5'h08: r = {2'd2, 24'hCB8600};
            5'h09: r = {2'd3, 24'hE280B0};
            5'h0A: r = {2'd2, 24'hC5A000};
            5'h0B: r = {2'd3, 24'hE280B9};
            5'h0C: r = {2'd2, 24'hC59200};
            5'h0E: r = {2'd2, 24'hC5BD00};
            5'h11: r = {2'd3, 24'hE28098};
            5'h12: r = {2'd3, 24'hE28099};
            5'h13: r = {2'd3, 24'hE2809C};
            5'h14: r = {2'd3, 24'hE2809D};
            5'h15: r = {2'd3, 24'hE280A2};
            5'h16: r = {2'd3, 24'hE28093};
            5'h17: r = {2'd3, 24'hE28094};
            5'h18: r = {2'd2, 24'hCB9C00};
            5'h19: r = {2'd3, 24'hE284A2};
            5'h1A: r = {2'd2, 24'hC5A100};
            5'h1B: r = {2'd3, 24'hE280BA};
            5'h1C: r = {2'd2, 24'hC59300};
            5'h1E: r = {2'd2, 24'hC5BE00};
            5'h1F: r = {2'd2, 24'hC5B800};
            default: r = 26'd0;             // undefined codes: dropped
        endcase
        return r;
    endfunction

    // Works out the output bytes one accepted input byte causes and queues them.
    task automatic sanitize_byte(input logic [7:0] b, input logic is_final);
        logic [7:0]   work [4];
        logic [25:0]  row;
        logic [7:0]   cur;
        logic         ok;
        logic         done;
        utf8_result_t run_q [$];
        utf8_result_t r;
        int           n;
        int           p;
        int           k;
        int           len;
        int           avail;
        n = 0;
        for (k = 0; k < held_n; k++)
        begin
            work[n] = held[k];
            n = n + 1;
        end
        work[n] = b;
        n = n + 1;
        held_n   = 2'd0;
        p = 0;
        while (p < n)
        begin
            cur  = work[p];
            len  = lead_len(cur);
            done = 1'b0;
            if (len == 1)
            begin
                run_q.push_back({cur, 1'b1, 1'b0});
                p = p + 1;
                done = 1'b1;
            end
            else if (len >= 2)
            begin
                avail = n - p;
                ok = 1'b1;
                for (k = 1; k < len && k < avail; k++)
                    if ((work[p + k] & MASK_CONT) != PAT_CONT)
                        ok = 1'b0;
                if (ok && avail >= len)
                begin
                    for (k = 0; k < len; k++)
                        run_q.push_back({work[p + k], k == 0, 1'b0});
                    p = p + len;
                    done = 1'b1;
                end
                else if (ok && !is_final)
                begin
                    // sequence still incomplete: keep it for the next byte
                    for (k = 0; k < avail; k++)
                        held[k] = work[p + k];
                    held_n   = avail[1:0];
                    p = n;
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                // lead fails: convert it alone, rescan what follows
                if (cur < NBSP_CODE)
                begin
                    row = cp1252_utf8(cur[4:0]);
                    for (k = 0; k < row[25:24]; k++)
                        run_q.push_back({row[23 - 8 * k -: 8], k == 0, 1'b0});
                end
                else if (cur < LATIN_CODE)
                begin
                    run_q.push_back({LEAD_C2, 1'b1, 1'b0});
                    run_q.push_back({cur, 1'b0, 1'b0});
                end
                else
                begin
                    run_q.push_back({LEAD_C3, 1'b1, 1'b0});
                    run_q.push_back({cur - LATIN_OFS, 1'b0, 1'b0});
                end
                p = p + 1;
            end
        end
        for (k = 0; k < run_q.size(); k++)
        begin
            r = run_q[k];
            r.fin = (k == run_q.size() - 1);
            expected_utf8.push_back(r);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back({b, last, drain_next});
        drain_next = 1'b0;
    endtask

    // Gap length: mostly none or short, now and then long; none in a calm stretch
    function automatic int pick_gap(input bit calm);
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            g = 0;
        else if (r < 90)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(10, 40);
        return g;
    endfunction

    // Driver: one input transfer per push && !full edge. The next byte is only
    // put up once the current one has gone, so push is assigned once per edge.
    int        send_gap  = 0;
    bit        calm_send = 1'b0;
    raw_byte_t next_in;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (push && !full)
                sanitize_byte(in_byte, in_last);
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    push <= 1'b0;
                end
                else if (pending_bytes.size() != 0 &&
                         (!pending_bytes[0].drain_first || expected_utf8.size() == 0))
                begin
                    next_in = pending_bytes.pop_front();
                    push    <= 1'b1;
                    in_byte <= next_in.data;
                    in_last <= next_in.last;
                    if ($urandom_range(0, 39) == 0)
                        calm_send = !calm_send;
                    send_gap = pick_gap(calm_send);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: checks each output transfer against the oldest expected byte
    // and throttles pop with random stalls of its own.
    int           pop_wait  = 0;
    bit           calm_recv = 1'b0;
    utf8_result_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_wait = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_utf8.size() == 0)
                begin
                    err_count = err_count + 1;
                    $display("%0t: unexpected transfer: expected none, got %h start %b last %b",
                             $time, out_byte, char_start, run_last);
                end
                else
                begin
                    want = expected_utf8.pop_front();
                    if (out_byte !== want.data)
                    begin
                        err_count = err_count + 1;
                        $display("%0t: out_byte: expected %h, got %h",
                                 $time, want.data, out_byte);
                    end
                    if (char_start !== want.start)
                    begin
                        err_count = err_count + 1;
                        $display("%0t: char_start: expected %b, got %b",
                                 $time, want.start, char_start);
                    end
                    if (run_last !== want.fin)
                    begin
                        err_count = err_count + 1;
                        $display("%0t: run_last: expected %b, got %b",
                                 $time, want.fin, run_last);
                    end
                end
            end
            if (pop_wait > 0)
            begin
                pop_wait = pop_wait - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 59) == 0)
                    calm_recv = !calm_recv;
                pop_wait = pick_gap(calm_recv);
            end
        end
    end

    // Watchdog: cycles since the last transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [7:0] word_bytes [$];
        int         random_count;
        int         kind;
        int         seq_n;
        int         n_cont;
        int         i;
        bit         mid_pause_done;
        bit         timed_out;
        random_count   = 0;
        mid_pause_done = 1'b0;
        timed_out      = 1'b0;

        // Directed: ASCII extremes including the zero byte, one good sequence
        // of each length, the ends of the 0x80..0x9F corner and all its undefined codes
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte(8'h80, 1'b1);
        // stray continuations: table hits and dropped codes
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'h8D, 1'b0);
        queue_byte(8'h8F, 1'b0);
        queue_byte(8'h90, 1'b0);
        queue_byte(8'h9D, 1'b0);
        queue_byte(8'h9F, 1'b0);
        // Latin-1 ranges and leads that can never start a sequence
        queue_byte(8'hA0, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hF8, 1'b0);
        // bad continuation, then a string that ends inside a sequence
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b1);

        // the first random byte waits for the directed results to drain
        drain_next = 1'b1;

        // Random strings: mostly well-formed characters with random payload,
        // the rest noise bytes, truncated and broken sequences
        while (random_count < RANDOM_ITEMS)
        begin
            word_bytes.delete();
            repeat ($urandom_range(1, 10))
            begin
                kind = $urandom_range(0, 99);
                if (kind < 30)
                    word_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
                else if (kind < 45)
                    word_bytes.push_back(8'($urandom_range(8'h00, 8'hFF)));
                else
                begin
                    seq_n = $urandom_range(2, 4);
                    if (seq_n == 2)
                        word_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    else if (seq_n == 3)
                        word_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    else
                        word_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                    if (kind < 85)
                        n_cont = seq_n - 1;
                    else
                        n_cont = $urandom_range(0, seq_n - 2);
                    repeat (n_cont)
                        word_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    if (kind >= 93)
                    begin
                        if ($urandom_range(0, 1) == 1)
                            word_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
                        else
                            word_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                    end
                end
            end
            for (i = 0; i < word_bytes.size(); i++)
            begin
                if (!mid_pause_done && random_count >= RANDOM_ITEMS / 2)
                begin
                    drain_next     = 1'b1;
                    mid_pause_done = 1'b1;
                end
                // end of string on the last byte, and now and then mid-word
                queue_byte(word_bytes[i],
                           (i == word_bytes.size() - 1) || ($urandom_range(0, 39) == 0));
                random_count = random_count + 1;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge, clear of the edge the transfers happen on
        while (!timed_out &&
               (pending_bytes.size() != 0 || push || expected_utf8.size() != 0))
        begin
            @(negedge clk);
            if (idle_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end
        // let any stray output surface before the verdict
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge clk);

        if (!timed_out && err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
